// ===== hdl/rwl_pkg.sv =====
`timescale 1ns / 1ps

package rwl_pkg;

    localparam int REQUESTERS = 64;
    localparam int IDX_W      = $clog2(REQUESTERS);
    localparam int CMD_W      = 3;
    localparam int REQ_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int HELD_W     = 3;
    localparam int MODE_W     = 4;
    localparam int CNT_W      = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // bit positions within a holder entry
    localparam int BIT_TRANS = 0;
    localparam int BIT_READ  = 1;
    localparam int BIT_WRITE = 2;
    localparam int BIT_WAIT  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE        = 3'd0,
        CMD_READ         = 3'd1,
        CMD_UNLOCK       = 3'd2,
        CMD_TRANS_LOCK   = 3'd3,
        CMD_TRANS_UNLOCK = 3'd4,
        CMD_UPGRADE      = 3'd5,
        CMD_DOWNGRADE    = 3'd6
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT    = 2'd0,
        ST_WAIT     = 2'd1,
        ST_SHUTDOWN = 2'd2
    } status_e;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [REQ_W-1:0] requester;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HELD_W-1:0]   held_mode;
        logic                wake;
    } out_word_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [MODE_W-1:0] data;
    } mode_wr_t;

    typedef struct packed {
        logic [CNT_W-1:0] reader_count;
        logic [CNT_W-1:0] trans_count;
        logic [CNT_W-1:0] waiter_count;
        logic             write_held;
        logic             writer_pending;
    } lock_state_t;

endpackage

// ===== hdl/rw_transaction_lock_arbiter.sv =====
`timescale 1ns / 1ps
// Flow: an accepted word waits in the stage-1 register while out_stall holds the
// output register full, then moves there and is presented on out_data.
// Throughput: one word per cycle unless stalled; the holder-mode memory is read on
// accept, written back as a word leaves stage 1, bypassed for back-to-back requesters.
// Reset: rst_n clears all counters, flags, holder entries (through per-entry
// valid bits) and the shutdown register at once; no clearing pass is needed.

module rw_transaction_lock_arbiter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rwl_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rwl_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import rwl_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    in_word_t          s1_word_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_word_t         out_word_reg;
    out_word_t         out_word_next;
    logic              shutting_down_reg;
    logic              shutting_down_next;

    logic              out_free;
    logic              fire;
    logic              accept;
    mode_wr_t          mode_wr;
    logic [MODE_W-1:0] mode_rd;
    logic [MODE_W-1:0] mode_new;
    status_e           core_status;
    logic              core_wake;

    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign s1_valid_next      = accept || (s1_valid_reg && !fire);
    assign out_valid_next     = fire || (out_valid_reg && out_stall);
    assign shutting_down_next = (cfg_valid && cfg_ready) ? cfg_data : shutting_down_reg;

    assign mode_wr.en   = fire;
    assign mode_wr.idx  = s1_word_reg.requester[IDX_W-1:0];
    assign mode_wr.data = mode_new;

    rwl_mode_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (in_data.requester[IDX_W-1:0]),
        .wr      (mode_wr),
        .rd_data (mode_rd)
    );

    rwl_lock_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .cmd           (s1_word_reg.cmd),
        .mode_in       (mode_rd),
        .shutting_down (shutting_down_reg),
        .mode_out      (mode_new),
        .status        (core_status),
        .wake          (core_wake)
    );

    always_comb
    begin
        out_word_next.status    = STATUS_W'(core_status);
        out_word_next.held_mode = mode_new[HELD_W-1:0];
        out_word_next.wake      = core_wake;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= in_data;
        end
        if (fire)
        begin
            out_word_reg <= out_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            shutting_down_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            out_valid_reg     <= out_valid_next;
            shutting_down_reg <= shutting_down_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

// ===== hdl/rwl_mode_store.sv =====
`timescale 1ns / 1ps

module rwl_mode_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [rwl_pkg::IDX_W-1:0]    rd_idx,
    input  rwl_pkg::mode_wr_t            wr,
    output logic [rwl_pkg::MODE_W-1:0]   rd_data
);
    import rwl_pkg::*;

    logic [MODE_W-1:0]     mode_mem [REQUESTERS];
    logic [REQUESTERS-1:0] valid_reg;
    logic [MODE_W-1:0]     rd_q_reg;
    logic                  hit_reg;
    logic                  fwd_reg;
    logic [MODE_W-1:0]     fwd_data_reg;
    logic                  fwd_next;

    assign fwd_next = wr.en && (wr.idx == rd_idx);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mode_mem[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mode_mem[rd_idx];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_idx];
                fwd_reg <= fwd_next;
            end
        end
    end

    // an entry never written reads as nothing held
    assign rd_data = fwd_reg ? fwd_data_reg : (hit_reg ? rd_q_reg : '0);

endmodule

// ===== hdl/rwl_lock_core.sv =====
`timescale 1ns / 1ps

module rwl_lock_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [rwl_pkg::CMD_W-1:0]    cmd,
    input  logic [rwl_pkg::MODE_W-1:0]   mode_in,
    input  logic                         shutting_down,
    output logic [rwl_pkg::MODE_W-1:0]   mode_out,
    output rwl_pkg::status_e             status,
    output logic                         wake
);
    import rwl_pkg::*;

    typedef struct packed {
        lock_state_t       st;
        logic [MODE_W-1:0] mode;
        logic              wake;
        status_e           status;
    } work_t;

    lock_state_t state_reg;
    lock_state_t state_next;
    work_t       w;

    function automatic logic [CNT_W-1:0] cnt_inc(logic [CNT_W-1:0] c);
        return (c < CNT_MAX) ? c + CNT_W'(1) : CNT_MAX;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dec(logic [CNT_W-1:0] c);
        return (c != '0) ? c - CNT_W'(1) : '0;
    endfunction

    function automatic logic idle_waiters(lock_state_t s);
        return (s.reader_count == '0) && (s.trans_count == '0) && !s.write_held
            && (s.waiter_count != '0);
    endfunction

    function automatic work_t drop_write(work_t x);
        work_t r;
        r = x;
        r.st.write_held = 1'b0;
        if (r.st.waiter_count != '0)
        begin
            r.wake = 1'b1;
        end
        r.mode[BIT_WRITE] = 1'b0;
        return r;
    endfunction

    function automatic work_t do_write(work_t x);
        work_t            r;
        logic [CNT_W-1:0] other_trans;
        r = x;
        r.status = ST_GRANT;
        if (!r.mode[BIT_WRITE])
        begin
            if (r.mode[BIT_READ])
            begin
                r.st.reader_count = cnt_dec(r.st.reader_count);
                r.mode[BIT_READ]  = 1'b0;
            end
            other_trans = r.mode[BIT_TRANS] ? cnt_dec(r.st.trans_count) : r.st.trans_count;
            if ((r.st.reader_count != '0) || (other_trans != '0) || r.st.write_held)
            begin
                r.st.writer_pending = 1'b1;
                r.status            = ST_WAIT;
            end
            else
            begin
                r.st.write_held     = 1'b1;
                r.st.writer_pending = 1'b0;
                r.mode[BIT_WRITE]   = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic work_t do_read(work_t x);
        work_t r;
        r = x;
        r.status = ST_GRANT;
        if (r.mode[BIT_WRITE])
        begin
            r = drop_write(r);
        end
        if (r.mode[BIT_READ])
        begin
            r.st.reader_count = cnt_dec(r.st.reader_count);
            r.mode[BIT_READ]  = 1'b0;
        end
        if (r.st.write_held || r.st.writer_pending)
        begin
            r.status = ST_WAIT;
        end
        else
        begin
            r.st.reader_count = cnt_inc(r.st.reader_count);
            r.mode[BIT_READ]  = 1'b1;
        end
        return r;
    endfunction

    function automatic work_t do_unlock(work_t x);
        work_t r;
        r = x;
        r.status = ST_GRANT;
        if (r.mode[BIT_WRITE])
        begin
            r = drop_write(r);
        end
        if (r.mode[BIT_READ])
        begin
            r.st.reader_count = cnt_dec(r.st.reader_count);
            if (idle_waiters(r.st))
            begin
                r.wake = 1'b1;
            end
            r.mode[BIT_READ] = 1'b0;
        end
        return r;
    endfunction

    function automatic work_t do_trans_lock(work_t x, logic sd);
        work_t r;
        r = x;
        r.status = ST_GRANT;
        if (sd)
        begin
            r.status = ST_SHUTDOWN;
        end
        else if (!r.mode[BIT_TRANS])
        begin
            if ((r.st.writer_pending || r.st.write_held) && !r.mode[BIT_WRITE])
            begin
                r.status = ST_WAIT;
            end
            else
            begin
                r.st.trans_count  = cnt_inc(r.st.trans_count);
                r.mode[BIT_TRANS] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic work_t do_trans_unlock(work_t x);
        work_t r;
        r = x;
        r.status = ST_GRANT;
        if (r.mode[BIT_TRANS])
        begin
            r.st.trans_count = cnt_dec(r.st.trans_count);
            if (idle_waiters(r.st))
            begin
                r.wake = 1'b1;
            end
            r.mode[BIT_TRANS] = 1'b0;
        end
        return r;
    endfunction

    always_comb
    begin
        w.st     = state_reg;
        w.mode   = mode_in;
        w.wake   = 1'b0;
        w.status = ST_GRANT;

        // a retrying requester stops counting as a waiter
        if (w.mode[BIT_WAIT])
        begin
            w.mode[BIT_WAIT]  = 1'b0;
            w.st.waiter_count = cnt_dec(w.st.waiter_count);
            if (w.st.waiter_count == '0)
            begin
                w.st.writer_pending = 1'b0;
            end
        end

        case (cmd_e'(cmd))
            CMD_WRITE:        w = do_write(w);
            CMD_READ:         w = do_read(w);
            CMD_UNLOCK:       w = do_unlock(w);
            CMD_TRANS_LOCK:   w = do_trans_lock(w, shutting_down);
            CMD_TRANS_UNLOCK: w = do_trans_unlock(w);
            CMD_UPGRADE:
            begin
                if (w.mode[BIT_WRITE])
                begin
                    w.status = ST_GRANT;
                end
                else if (w.mode[BIT_READ])
                begin
                    w = do_write(w);
                end
                else
                begin
                    w = do_read(w);
                end
            end
            CMD_DOWNGRADE:
            begin
                if (w.mode[BIT_WRITE])
                begin
                    w = do_read(w);
                end
                else if (w.mode[BIT_READ])
                begin
                    w = do_unlock(w);
                end
                else
                begin
                    w = do_trans_unlock(w);
                end
            end
            default:
            begin
                w.status = ST_GRANT;
            end
        endcase

        if (w.status == ST_WAIT)
        begin
            w.mode[BIT_WAIT]  = 1'b1;
            w.st.waiter_count = cnt_inc(w.st.waiter_count);
        end
    end

    assign state_next = fire ? w.st : state_reg;
    assign mode_out   = w.mode;
    assign status     = w.status;
    assign wake       = w.wake;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
